// ===== hw/rtl/sdfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_pkg
// Shared types and constants for the standard deviation pipeline.
// ----------------------------------------------------------------------------
package sdfs_pkg;

    localparam int DEF_FRACTION_BITS = 16;
    // root of V * 2^(2F) needs 63 + F bits since V < 2^126
    localparam int ROOT_BASE_BITS    = 63;
    localparam int N_BITS            = 32;
    localparam int OUT_BITS          = 48;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_ZERO_N   = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;
    localparam t_status ST_NEG_VAR  = 2'd3;

    // sideband that travels with every item through the pipeline
    typedef struct packed {
        logic                valid;
        t_status             status;
        logic [N_BITS-1:0]   samples;
    } t_tag;

endpackage
`default_nettype wire

// ===== hw/rtl/std_dev_from_sums.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// std_dev_from_sums
// Population standard deviation from sample count, sum and sum of squares.
// ----------------------------------------------------------------------------
// Fully pipelined: an item may be started every clock cycle and busy is high
// only in the first cycle after reset. Each result appears on the o_ ports
// for one cycle, marked by o_valid, after its start has passed through four
// stages that form A*N - B^2, one square root stage per root bit, one
// division stage per quotient bit and one output register. Results come out
// in start order and must be taken when shown; there is no back pressure.
// ----------------------------------------------------------------------------
module std_dev_from_sums #(
    parameter int FRACTION_BITS = sdfs_pkg::DEF_FRACTION_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        i_samples,
    input  wire logic signed [63:0] i_sample_sum,
    input  wire logic [63:0]        i_sum_squares_low,
    input  wire logic [29:0]        i_sum_squares_high,
    output logic                    o_valid,
    output logic [47:0]             o_std_dev_fixed,
    output logic [1:0]              o_status
);
    import sdfs_pkg::*;

    localparam int RW = ROOT_BASE_BITS + FRACTION_BITS;

    logic          r_busy;
    t_tag          w_front_tag, w_root_tag;
    logic [2*RW-1:0] w_radicand;
    logic [RW-1:0] w_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    sdfs_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (start & ~r_busy),
        .i_samples          (i_samples),
        .i_sample_sum       (i_sample_sum),
        .i_sum_squares_low  (i_sum_squares_low),
        .i_sum_squares_high (i_sum_squares_high),
        .o_tag              (w_front_tag),
        .o_radicand         (w_radicand)
    );

    sdfs_isqrt #(.FRACTION_BITS(FRACTION_BITS)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (w_front_tag),
        .i_radicand (w_radicand),
        .o_tag      (w_root_tag),
        .o_root     (w_root)
    );

    sdfs_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_root_tag),
        .i_root   (w_root),
        .o_valid  (o_valid),
        .o_value  (o_std_dev_fixed),
        .o_status (o_status)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/sdfs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_front
// Error checks and variance numerator V = A*N - B^2 in four register stages;
// the last stage also scales V by 2^(2F) for the square root.
// ----------------------------------------------------------------------------
module sdfs_front #(
    parameter int FRACTION_BITS = sdfs_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [31:0]          i_samples,
    input  wire logic signed [63:0]   i_sample_sum,
    input  wire logic [63:0]          i_sum_squares_low,
    input  wire logic [29:0]          i_sum_squares_high,
    output sdfs_pkg::t_tag            o_tag,
    output logic [2*(sdfs_pkg::ROOT_BASE_BITS+FRACTION_BITS)-1:0] o_radicand
);
    import sdfs_pkg::*;

    localparam int RW = ROOT_BASE_BITS + FRACTION_BITS;
    localparam int XW = 2 * RW;

    // stage 1: absolute value of B
    t_tag        r1_tag;
    logic [63:0] r1_absb;
    logic [93:0] r1_a;
    logic [63:0] n1_absb;

    assign n1_absb = i_sample_sum[63] ? (~i_sample_sum + 64'd1) : i_sample_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.valid <= 1'b0;
        end else begin
            r1_tag.valid <= i_valid;
        end
        r1_tag.status  <= ST_OK;
        r1_tag.samples <= i_samples;
        r1_absb        <= n1_absb;
        r1_a           <= {i_sum_squares_high, i_sum_squares_low};
    end

    // stage 2: checks and partial products of A*N and B^2
    t_tag        r2_tag;
    t_status     n2_status;
    logic [63:0] r2_p0, r2_p1, r2_q00, r2_q01, r2_q11;
    logic [61:0] r2_p2;

    always_comb begin
        if (r1_tag.samples == 32'd0) begin
            n2_status = ST_ZERO_N;
        end else if (r1_absb[63:32] >= r1_tag.samples) begin
            n2_status = ST_OVERFLOW;
        end else begin
            n2_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag.valid <= 1'b0;
        end else begin
            r2_tag.valid <= r1_tag.valid;
        end
        r2_tag.status  <= n2_status;
        r2_tag.samples <= r1_tag.samples;
        r2_p0  <= 64'(r1_a[31:0])  * 64'(r1_tag.samples);
        r2_p1  <= 64'(r1_a[63:32]) * 64'(r1_tag.samples);
        r2_p2  <= 62'(r1_a[93:64]) * 62'(r1_tag.samples);
        r2_q00 <= 64'(r1_absb[31:0])  * 64'(r1_absb[31:0]);
        r2_q01 <= 64'(r1_absb[31:0])  * 64'(r1_absb[63:32]);
        r2_q11 <= 64'(r1_absb[63:32]) * 64'(r1_absb[63:32]);
    end

    // stage 3: recombine A*N and B^2
    t_tag         r3_tag;
    logic [125:0] r3_an;
    logic [127:0] r3_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag.valid <= 1'b0;
        end else begin
            r3_tag.valid <= r2_tag.valid;
        end
        r3_tag.status  <= r2_tag.status;
        r3_tag.samples <= r2_tag.samples;
        r3_an <= 126'(r2_p0) + (126'(r2_p1) << 32) + (126'(r2_p2) << 64);
        r3_b2 <= 128'(r2_q00) + (128'(r2_q01) << 33) + (128'(r2_q11) << 64);
    end

    // stage 4: V = A*N - B^2, sign check
    t_tag         r4_tag;
    logic [XW-1:0] r4_x;
    logic [127:0] n4_diff;
    logic         n4_neg;

    assign n4_neg  = 128'(r3_an) < r3_b2;
    assign n4_diff = 128'(r3_an) - r3_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag.valid <= 1'b0;
        end else begin
            r4_tag.valid <= r3_tag.valid;
        end
        r4_tag.samples <= r3_tag.samples;
        r4_tag.status  <= (r3_tag.status == ST_OK && n4_neg) ? ST_NEG_VAR
                                                               : r3_tag.status;
        r4_x <= XW'(n4_diff[125:0]) << (2 * FRACTION_BITS);
    end

    assign o_tag      = r4_tag;
    assign o_radicand = r4_x;

endmodule
`default_nettype wire

// ===== hw/rtl/sdfs_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sdfs_isqrt #(
    parameter int FRACTION_BITS = sdfs_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sdfs_pkg::t_tag       i_tag,
    input  wire logic [2*(sdfs_pkg::ROOT_BASE_BITS+FRACTION_BITS)-1:0] i_radicand,
    output sdfs_pkg::t_tag            o_tag,
    output logic [sdfs_pkg::ROOT_BASE_BITS+FRACTION_BITS-1:0] o_root
);
    import sdfs_pkg::*;

    localparam int RW = ROOT_BASE_BITS + FRACTION_BITS;
    localparam int XW = 2 * RW;

    t_tag          s_tag [0:RW];
    logic [RW+1:0] s_rem [0:RW];
    logic [RW-1:0] s_res [0:RW];
    logic [XW-1:0] s_x   [0:RW];

    assign s_tag[0] = i_tag;
    assign s_rem[0] = '0;
    assign s_res[0] = '0;
    assign s_x[0]   = i_radicand;

    for (genvar k = 0; k < RW; k++) begin : g_step
        t_tag          r_tag;
        logic [RW+1:0] r_rem;
        logic [RW-1:0] r_res;
        logic [XW-1:0] r_x;
        logic [RW+1:0] w_cur, w_trial;
        logic          w_ge;

        // remainder stays below 2^RW until the last step
        assign w_cur   = {s_rem[k][RW-1:0], s_x[k][XW-1:XW-2]};
        assign w_trial = {s_res[k], 2'b01};
        assign w_ge    = w_cur >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag.valid <= 1'b0;
            end else begin
                r_tag.valid <= s_tag[k].valid;
            end
            r_tag.status  <= s_tag[k].status;
            r_tag.samples <= s_tag[k].samples;
            r_rem <= w_ge ? (w_cur - w_trial) : w_cur;
            r_res <= {s_res[k][RW-2:0], w_ge};
            r_x   <= s_x[k] << 2;
        end

        assign s_tag[k+1] = r_tag;
        assign s_rem[k+1] = r_rem;
        assign s_res[k+1] = r_res;
        assign s_x[k+1]   = r_x;
    end

    assign o_tag  = s_tag[RW];
    assign o_root = s_res[RW];

endmodule
`default_nettype wire

// ===== hw/rtl/sdfs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdfs_div
// Pipelined restoring division of the root by N, one quotient bit per
// stage, then saturation and error masking in an output register.
// ----------------------------------------------------------------------------
module sdfs_div #(
    parameter int FRACTION_BITS = sdfs_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sdfs_pkg::t_tag       i_tag,
    input  wire logic [sdfs_pkg::ROOT_BASE_BITS+FRACTION_BITS-1:0] i_root,
    output logic                      o_valid,
    output logic [sdfs_pkg::OUT_BITS-1:0] o_value,
    output sdfs_pkg::t_status         o_status
);
    import sdfs_pkg::*;

    localparam int RW = ROOT_BASE_BITS + FRACTION_BITS;

    t_tag              s_tag [0:RW];
    logic [N_BITS-1:0] s_rem [0:RW];
    logic [RW-1:0]     s_q   [0:RW];

    assign s_tag[0] = i_tag;
    assign s_rem[0] = '0;
    assign s_q[0]   = i_root;

    for (genvar k = 0; k < RW; k++) begin : g_step
        t_tag              r_tag;
        logic [N_BITS-1:0] r_rem;
        logic [RW-1:0]     r_q;
        logic [N_BITS:0]   w_cur, w_diff;
        logic              w_ge;

        // dividend bits leave at the top, quotient bits enter at the bottom
        assign w_cur  = {s_rem[k], s_q[k][RW-1]};
        assign w_diff = w_cur - {1'b0, s_tag[k].samples};
        assign w_ge   = w_cur >= {1'b0, s_tag[k].samples};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag.valid <= 1'b0;
            end else begin
                r_tag.valid <= s_tag[k].valid;
            end
            r_tag.status  <= s_tag[k].status;
            r_tag.samples <= s_tag[k].samples;
            r_rem <= w_ge ? w_diff[N_BITS-1:0] : w_cur[N_BITS-1:0];
            r_q   <= {s_q[k][RW-2:0], w_ge};
        end

        assign s_tag[k+1] = r_tag;
        assign s_rem[k+1] = r_rem;
        assign s_q[k+1]   = r_q;
    end

    logic                r_valid;
    logic [OUT_BITS-1:0] r_value;
    t_status             r_status;
    logic [OUT_BITS-1:0] n_value;

    always_comb begin
        if (s_tag[RW].status != ST_OK) begin
            n_value = '0;
        end else if (|s_q[RW][RW-1:OUT_BITS]) begin
            n_value = '1;
        end else begin
            n_value = s_q[RW][OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_tag[RW].valid;
        end
        r_value  <= n_value;
        r_status <= s_tag[RW].status;
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule
`default_nettype wire
